FILE: rtl/core/sip_pkg.sv
// ----------------------------------------------------------------------------
// sip_pkg
// Shared constants and types for the segment intersection point block.
// ----------------------------------------------------------------------------
package sip_pkg;

   localparam int SIP_COORD_WIDTH = 16;
   localparam int SIP_QUEUE_DEPTH = 4;

   // per-item decision bits handed from the front to the back
   typedef struct packed {
      logic hit;
      logic parallel;
      logic neg_x;
      logic neg_y;
   } sip_flags_type;

endpackage

FILE: rtl/core/segment_intersection_point_top.sv
// ----------------------------------------------------------------------------
// segment_intersection_point_top
// 2D segment intersection in signed fixed point (Q12.4 at 16 bits).
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one beat carries segment A (a_start, a_end) and segment B
//   (b_start, b_end). rsp_ channel: one beat per request with hit, parallel
//   and the crossing point (zero unless hit). Both channels are valid/ready.
//   Throughput: one beat per cycle, sustained while rsp_ready holds, set by
//   a fully pipelined datapath: three front stages (differences, cross
//   products, determinant), a 4-entry queue, a partial-product stage, a sum
//   stage and COORD_WIDTH one-bit divider stages, then the result register.
//   Reset (synchronous, active high) empties every stage and the queue.
//   When the receiver stalls, the back half freezes; the front half keeps
//   accepting until the queue fills, then req_ready drops.
//   Results leave in request order.
// ----------------------------------------------------------------------------
module segment_intersection_point_top #(
   parameter int COORD_WIDTH = sip_pkg::SIP_COORD_WIDTH,
   parameter int QUEUE_DEPTH = sip_pkg::SIP_QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_a_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_a_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_a_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_a_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_b_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_b_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_b_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_b_end_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic                          rsp_parallel,
   output logic signed [COORD_WIDTH-1:0] rsp_point_x,
   output logic signed [COORD_WIDTH-1:0] rsp_point_y
);

   // queue payload: start x/y, |dx|, |dy|, |tn|, |d|
   localparam int QW = 4 * COORD_WIDTH + 2 * (2 * COORD_WIDTH + 1);

   logic                   fq_valid, fq_ready, qb_valid, qb_ready;
   sip_pkg::sip_flags_type fq_flags, qb_flags;
   logic [QW-1:0]          fq_data, qb_data;
   logic [COORD_WIDTH-1:0] pt_x, pt_y;

   // front: differences, cross products, classification
   sip_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .x1         (req_a_start_x),
      .y1         (req_a_start_y),
      .x2         (req_a_end_x),
      .y2         (req_a_end_y),
      .x3         (req_b_start_x),
      .y3         (req_b_start_y),
      .x4         (req_b_end_x),
      .y4         (req_b_end_y),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_flags (fq_flags),
      .push_data  (fq_data)
   );

   // decouples the two halves so each can stall on its own
   sip_queue #(
      .DATA_W (QW),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_flags (fq_flags),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_flags  (qb_flags),
      .pop_data   (qb_data)
   );

   // back: scale, divide, form the point
   sip_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (qb_valid),
      .pop_ready    (qb_ready),
      .pop_flags    (qb_flags),
      .pop_data     (qb_data),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_hit      (rsp_hit),
      .out_parallel (rsp_parallel),
      .out_point_x  (pt_x),
      .out_point_y  (pt_y)
   );

   assign rsp_point_x = $signed(pt_x);
   assign rsp_point_y = $signed(pt_y);

endmodule

FILE: rtl/core/sip_queue.sv
// ----------------------------------------------------------------------------
// sip_queue
// Small FIFO between the classifier front and the divider back.
// ----------------------------------------------------------------------------
module sip_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = sip_pkg::SIP_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  sip_pkg::sip_flags_type push_flags,
   input  logic [DATA_W-1:0]     push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output sip_pkg::sip_flags_type pop_flags,
   output logic [DATA_W-1:0]     pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sip_pkg::sip_flags_type flags_ff [DEPTH];
   logic [DATA_W-1:0]      data_ff  [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_flags  = flags_ff[rd_ptr_ff];
   assign pop_data   = data_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         flags_ff[wr_ptr_ff] <= push_flags;
         data_ff[wr_ptr_ff]  <= push_data;
      end
   end

endmodule

FILE: rtl/core/sip_front.sv
// ----------------------------------------------------------------------------
// sip_front
// Three-stage front: differences, cross products, determinant and numerators,
// then hit/parallel classification into the queue.
// ----------------------------------------------------------------------------
module sip_front #(
   parameter int COORD_WIDTH = sip_pkg::SIP_COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] x1,
   input  logic signed [COORD_WIDTH-1:0] y1,
   input  logic signed [COORD_WIDTH-1:0] x2,
   input  logic signed [COORD_WIDTH-1:0] y2,
   input  logic signed [COORD_WIDTH-1:0] x3,
   input  logic signed [COORD_WIDTH-1:0] y3,
   input  logic signed [COORD_WIDTH-1:0] x4,
   input  logic signed [COORD_WIDTH-1:0] y4,
   output logic                          push_valid,
   input  logic                          push_ready,
   output sip_pkg::sip_flags_type        push_flags,
   output logic [4*COORD_WIDTH+2*(2*COORD_WIDTH+1)-1:0] push_data
);

   localparam int W  = COORD_WIDTH;
   localparam int DW = W + 1;        // coordinate differences
   localparam int PW = 2 * DW;       // cross products
   localparam int NW = PW + 1;       // d, tn, un
   localparam int MW = 2 * W + 1;    // magnitude of d (and of tn on a hit)

   logic en;

   // stage 1: differences
   logic                 f1_v_ff;
   logic signed [DW-1:0] sx_ff, sy_ff, rx_ff, ry_ff, wx_ff, wy_ff, dx_ff, dy_ff;
   logic signed [DW-1:0] sx_in, sy_in, rx_in, ry_in, wx_in, wy_in, dx_in, dy_in;
   logic [W-1:0]         f1_x1_ff, f1_y1_ff;

   // stage 2: products
   logic                 f2_v_ff;
   logic signed [PW-1:0] sxry_ff, syrx_ff, wxry_ff, wyrx_ff, wxsy_ff, wysx_ff;
   logic signed [DW-1:0] f2_dx_ff, f2_dy_ff;
   logic [W-1:0]         f2_x1_ff, f2_y1_ff;

   // stage 3: determinant and numerators
   logic                 f3_v_ff;
   logic signed [NW-1:0] d_ff, tn_ff, un_ff, d_in, tn_in, un_in;
   logic signed [DW-1:0] f3_dx_ff, f3_dy_ff;
   logic [W-1:0]         f3_x1_ff, f3_y1_ff;

   // classification
   logic          d_zero, d_neg, t_in, u_in;
   logic [NW-1:0] abs_d, abs_t;
   logic [DW-1:0] abs_dx, abs_dy;

   assign en       = !f3_v_ff || push_ready;
   assign in_ready = en;

   always_comb begin
      sx_in = $signed({x1[W-1], x1}) - $signed({x2[W-1], x2});
      sy_in = $signed({y1[W-1], y1}) - $signed({y2[W-1], y2});
      rx_in = $signed({x3[W-1], x3}) - $signed({x4[W-1], x4});
      ry_in = $signed({y3[W-1], y3}) - $signed({y4[W-1], y4});
      wx_in = $signed({x1[W-1], x1}) - $signed({x3[W-1], x3});
      wy_in = $signed({y1[W-1], y1}) - $signed({y3[W-1], y3});
      dx_in = $signed({x2[W-1], x2}) - $signed({x1[W-1], x1});
      dy_in = $signed({y2[W-1], y2}) - $signed({y1[W-1], y1});
   end

   always_comb begin
      d_in  = $signed({sxry_ff[PW-1], sxry_ff}) - $signed({syrx_ff[PW-1], syrx_ff});
      tn_in = $signed({wxry_ff[PW-1], wxry_ff}) - $signed({wyrx_ff[PW-1], wyrx_ff});
      un_in = $signed({wxsy_ff[PW-1], wxsy_ff}) - $signed({wysx_ff[PW-1], wysx_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
         f3_v_ff <= 1'b0;
      end else if (en) begin
         f1_v_ff <= in_valid;
         f2_v_ff <= f1_v_ff;
         f3_v_ff <= f2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         rx_ff    <= rx_in;
         ry_ff    <= ry_in;
         wx_ff    <= wx_in;
         wy_ff    <= wy_in;
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         f1_x1_ff <= x1;
         f1_y1_ff <= y1;

         sxry_ff  <= sx_ff * ry_ff;
         syrx_ff  <= sy_ff * rx_ff;
         wxry_ff  <= wx_ff * ry_ff;
         wyrx_ff  <= wy_ff * rx_ff;
         wxsy_ff  <= wx_ff * sy_ff;
         wysx_ff  <= wy_ff * sx_ff;
         f2_dx_ff <= dx_ff;
         f2_dy_ff <= dy_ff;
         f2_x1_ff <= f1_x1_ff;
         f2_y1_ff <= f1_y1_ff;

         d_ff     <= d_in;
         tn_ff    <= tn_in;
         un_ff    <= un_in;
         f3_dx_ff <= f2_dx_ff;
         f3_dy_ff <= f2_dy_ff;
         f3_x1_ff <= f2_x1_ff;
         f3_y1_ff <= f2_y1_ff;
      end
   end

   // both parameters in [0,1]: numerator between 0 and d, whichever side d is on
   always_comb begin
      d_zero = (d_ff == '0);
      d_neg  = d_ff[NW-1];
      if (d_neg) begin
         t_in = (d_ff <= tn_ff) && (tn_ff <= $signed(NW'(0)));
         u_in = (d_ff <= un_ff) && (un_ff <= $signed(NW'(0)));
      end else begin
         t_in = ($signed(NW'(0)) <= tn_ff) && (tn_ff <= d_ff);
         u_in = ($signed(NW'(0)) <= un_ff) && (un_ff <= d_ff);
      end
      abs_d  = d_neg ? NW'(-d_ff) : NW'(d_ff);
      abs_t  = tn_ff[NW-1] ? NW'(-tn_ff) : NW'(tn_ff);
      abs_dx = f3_dx_ff[DW-1] ? DW'(-f3_dx_ff) : DW'(f3_dx_ff);
      abs_dy = f3_dy_ff[DW-1] ? DW'(-f3_dy_ff) : DW'(f3_dy_ff);

      push_flags.parallel = d_zero;
      push_flags.hit      = !d_zero && t_in && u_in;
      push_flags.neg_x    = f3_dx_ff[DW-1] ^ tn_ff[NW-1] ^ d_neg;
      push_flags.neg_y    = f3_dy_ff[DW-1] ^ tn_ff[NW-1] ^ d_neg;
   end

   assign push_valid = f3_v_ff;
   assign push_data  = {f3_x1_ff, f3_y1_ff, abs_dx[W-1:0], abs_dy[W-1:0],
                        abs_t[MW-1:0], abs_d[MW-1:0]};

endmodule

FILE: rtl/core/sip_back.sv
// ----------------------------------------------------------------------------
// sip_back
// Scales the A direction by |tn| and divides by |d| in a one-bit-per-stage
// pipelined divider for both axes, then forms the point.
// ----------------------------------------------------------------------------
module sip_back #(
   parameter int COORD_WIDTH = sip_pkg::SIP_COORD_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  sip_pkg::sip_flags_type pop_flags,
   input  logic [4*COORD_WIDTH+2*(2*COORD_WIDTH+1)-1:0] pop_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic                   out_hit,
   output logic                   out_parallel,
   output logic [COORD_WIDTH-1:0] out_point_x,
   output logic [COORD_WIDTH-1:0] out_point_y
);

   localparam int W   = COORD_WIDTH;
   localparam int MW  = 2 * W + 1;
   localparam int PRW = 3 * W + 1;   // |diff| * |tn|
   localparam int HW  = MW - (W + 1);

   logic en;

   logic [W-1:0]  in_x1, in_y1, in_adx, in_ady;
   logic [MW-1:0] in_mt, in_md;

   // partial product stage
   logic                   p_v_ff;
   sip_pkg::sip_flags_type p_flags_ff;
   logic [W-1:0]           p_x1_ff, p_y1_ff;
   logic [MW-1:0]          p_md_ff;
   logic [2*W:0]           pp_xlo_ff, pp_ylo_ff;
   logic [W+HW-1:0]        pp_xhi_ff, pp_yhi_ff;

   // divider stages, index 0 holds the full product
   logic                   v_ff     [W+1];
   sip_pkg::sip_flags_type flags_ff [W+1];
   logic [W-1:0]           x1_ff    [W+1];
   logic [W-1:0]           y1_ff    [W+1];
   logic [MW-1:0]          md_ff    [W+1];
   logic [PRW-1:0]         rem_x_ff [W+1];
   logic [PRW-1:0]         rem_y_ff [W+1];
   logic [W-1:0]           q_x_ff   [W+1];
   logic [W-1:0]           q_y_ff   [W+1];

   // result register
   logic                   out_v_ff;
   logic                   out_hit_ff, out_par_ff;
   logic [W-1:0]           out_x_ff, out_x_in, out_y_ff, out_y_in;

   assign en        = !out_v_ff || out_ready;
   assign pop_ready = en;
   assign {in_x1, in_y1, in_adx, in_ady, in_mt, in_md} = pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff   <= 1'b0;
         v_ff[0]  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         p_v_ff   <= pop_valid;
         v_ff[0]  <= p_v_ff;
         out_v_ff <= v_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_flags_ff  <= pop_flags;
         p_x1_ff     <= in_x1;
         p_y1_ff     <= in_y1;
         p_md_ff     <= in_md;
         pp_xlo_ff   <= in_adx * in_mt[W:0];
         pp_ylo_ff   <= in_ady * in_mt[W:0];
         pp_xhi_ff   <= in_adx * in_mt[MW-1:W+1];
         pp_yhi_ff   <= in_ady * in_mt[MW-1:W+1];

         flags_ff[0] <= p_flags_ff;
         x1_ff[0]    <= p_x1_ff;
         y1_ff[0]    <= p_y1_ff;
         md_ff[0]    <= p_md_ff;
         rem_x_ff[0] <= {pp_xhi_ff, (W+1)'(0)} + PRW'(pp_xlo_ff);
         rem_y_ff[0] <= {pp_yhi_ff, (W+1)'(0)} + PRW'(pp_ylo_ff);
         q_x_ff[0]   <= '0;
         q_y_ff[0]   <= '0;

         out_hit_ff  <= flags_ff[W].hit;
         out_par_ff  <= flags_ff[W].parallel;
         out_x_ff    <= out_x_in;
         out_y_ff    <= out_y_in;
      end
   end

   // restoring division, quotient MSB first; the quotient never exceeds |diff|
   for (genvar k = 0; k < W; k++) begin : g_div
      localparam int SH = W - 1 - k;
      logic [PRW-1:0] dsh;
      logic           ge_x, ge_y;

      always_comb begin
         dsh  = PRW'(md_ff[k]) << SH;
         ge_x = (rem_x_ff[k] >= dsh);
         ge_y = (rem_y_ff[k] >= dsh);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            flags_ff[k+1] <= flags_ff[k];
            x1_ff[k+1]    <= x1_ff[k];
            y1_ff[k+1]    <= y1_ff[k];
            md_ff[k+1]    <= md_ff[k];
            rem_x_ff[k+1] <= ge_x ? rem_x_ff[k] - dsh : rem_x_ff[k];
            rem_y_ff[k+1] <= ge_y ? rem_y_ff[k] - dsh : rem_y_ff[k];
            q_x_ff[k+1]   <= {q_x_ff[k][W-2:0], ge_x};
            q_y_ff[k+1]   <= {q_y_ff[k][W-2:0], ge_y};
         end
      end
   end

   // point = start +/- quotient; zero unless a hit
   always_comb begin
      out_x_in = '0;
      out_y_in = '0;
      if (flags_ff[W].hit) begin
         out_x_in = flags_ff[W].neg_x ? x1_ff[W] - q_x_ff[W] : x1_ff[W] + q_x_ff[W];
         out_y_in = flags_ff[W].neg_y ? y1_ff[W] - q_y_ff[W] : y1_ff[W] + q_y_ff[W];
      end
   end

   assign out_valid    = out_v_ff;
   assign out_hit      = out_hit_ff;
   assign out_parallel = out_par_ff;
   assign out_point_x  = out_x_ff;
   assign out_point_y  = out_y_ff;

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks segment_intersection_point_top against an exact in-bench predictor:
// directed corner cases, then random segment pairs under bursty sending and
// patterned response stalls. Every response beat is compared in order.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CW        = sip_pkg::SIP_COORD_WIDTH;
   localparam int LATENCY   = CW + 6;
   localparam int WDOG_MAX  = 2000;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct {
      coord_type ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
   } seg_pair_type;

   typedef struct {
      logic      hit;
      logic      parallel;
      coord_type px;
      coord_type py;
   } crossing_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   coord_type req_a_start_x = '0, req_a_start_y = '0, req_a_end_x = '0, req_a_end_y = '0;
   coord_type req_b_start_x = '0, req_b_start_y = '0, req_b_end_x = '0, req_b_end_y = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   logic      rsp_hit, rsp_parallel;
   coord_type rsp_point_x, rsp_point_y;

   crossing_type crossings_due[$];
   int           mismatches = 0;
   int           idle_cycles = 0;
   bit           stall_enable = 1'b0;
   bit           gap_enable = 1'b0;

   segment_intersection_point_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_a_start_x(req_a_start_x), .req_a_start_y(req_a_start_y),
      .req_a_end_x(req_a_end_x), .req_a_end_y(req_a_end_y),
      .req_b_start_x(req_b_start_x), .req_b_start_y(req_b_start_y),
      .req_b_end_x(req_b_end_x), .req_b_end_y(req_b_end_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_hit(rsp_hit), .rsp_parallel(rsp_parallel),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y)
   );

   always #10 clock = ~clock;

   // Numerator n within [0,d] (d > 0) or [d,0] (d < 0).
   function automatic bit param_in_unit(longint n, longint d);
      if (d < 0) return (n <= 0) && (n >= d);
      return (n >= 0) && (n <= d);
   endfunction

   // start + diff*tn/d, quotient truncated toward zero. Products of 17-bit
   // differences stay within 35 bits, diff*tn within 52, so 64 bits suffice.
   function automatic coord_type lerp_coord(longint start, longint diff, longint tn,
                                            longint d);
      longint q;
      q = (diff * tn) / d;   // SV signed division truncates toward zero
      return coord_type'(start + q);
   endfunction

   function automatic crossing_type predict_crossing(seg_pair_type s);
      crossing_type c;
      longint x1, y1, x2, y2, x3, y3, x4, y4;
      longint det, tn, un;
      x1 = longint'(s.ax0); y1 = longint'(s.ay0);
      x2 = longint'(s.ax1); y2 = longint'(s.ay1);
      x3 = longint'(s.bx0); y3 = longint'(s.by0);
      x4 = longint'(s.bx1); y4 = longint'(s.by1);
      c = '{1'b0, 1'b0, '0, '0};
      det = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
      if (det == 0) begin
         c.parallel = 1'b1;
         return c;
      end
      tn = (x1 - x3) * (y3 - y4) - (y1 - y3) * (x3 - x4);
      un = (x1 - x3) * (y1 - y2) - (y1 - y3) * (x1 - x2);
      if (param_in_unit(tn, det) && param_in_unit(un, det)) begin
         c.hit = 1'b1;
         c.px  = lerp_coord(x1, x2 - x1, tn, det);
         c.py  = lerp_coord(y1, y2 - y1, tn, det);
      end
      return c;
   endfunction

   function automatic seg_pair_type mk_pair(int ax0, int ay0, int ax1, int ay1,
                                            int bx0, int by0, int bx1, int by1);
      seg_pair_type s;
      s.ax0 = coord_type'(ax0); s.ay0 = coord_type'(ay0);
      s.ax1 = coord_type'(ax1); s.ay1 = coord_type'(ay1);
      s.bx0 = coord_type'(bx0); s.by0 = coord_type'(by0);
      s.bx1 = coord_type'(bx1); s.by1 = coord_type'(by1);
      return s;
   endfunction

   // Hold one beat on req_ until accepted; random gap first when enabled.
   task automatic send_pair(seg_pair_type s);
      if (gap_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_a_start_x <= s.ax0; req_a_start_y <= s.ay0;
      req_a_end_x   <= s.ax1; req_a_end_y   <= s.ay1;
      req_b_start_x <= s.bx0; req_b_start_y <= s.by0;
      req_b_end_x   <= s.bx1; req_b_end_y   <= s.by1;
      do @(posedge clock); while (!req_ready);
      crossings_due.push_back(predict_crossing(s));
   endtask

   task automatic idle_sender();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // Response checker: compare each beat with the oldest prediction.
   always @(posedge clock) begin
      crossing_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (crossings_due.size() == 0) begin
            report_mismatch("unexpected beat", 1, 0);
         end else begin
            want = crossings_due.pop_front();
            if (rsp_hit !== want.hit)
               report_mismatch("hit", longint'(rsp_hit), longint'(want.hit));
            if (rsp_parallel !== want.parallel)
               report_mismatch("parallel", longint'(rsp_parallel), longint'(want.parallel));
            if (rsp_point_x !== want.px)
               report_mismatch("point_x", longint'(rsp_point_x), longint'(want.px));
            if (rsp_point_y !== want.py)
               report_mismatch("point_y", longint'(rsp_point_y), longint'(want.py));
         end
      end
   end

   // Receiver stall pattern: runs of ready and not-ready of random length.
   int stall_run = 0;
   always @(posedge clock) begin
      if (!stall_enable) begin
         rsp_ready <= 1'b1;
      end else if (stall_run == 0) begin
         rsp_ready <= ~rsp_ready;
         stall_run <= rsp_ready ? $urandom_range(1, 8) : $urandom_range(1, 12);
      end else begin
         stall_run <= stall_run - 1;
      end
   end

   // Watchdog: cycles with no beat accepted on either side.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WDOG_MAX) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 5))
         0: return coord_type'($urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
         1: return coord_type'($signed($urandom_range(0, 64)) - 32);
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic seg_pair_type rand_pair();
      seg_pair_type s;
      s = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
            rand_coord(), rand_coord(), rand_coord(), rand_coord()};
      return s;
   endfunction

   // Build B as a segment through a point on A, so hits are common.
   function automatic seg_pair_type crossing_pair();
      seg_pair_type s;
      int           mx, my, span;
      span = $urandom_range(0, 1) ? 200 : 12000;
      s.ax0 = coord_type'($signed($urandom_range(0, 2 * span)) - span);
      s.ay0 = coord_type'($signed($urandom_range(0, 2 * span)) - span);
      s.ax1 = coord_type'($signed($urandom_range(0, 2 * span)) - span);
      s.ay1 = coord_type'($signed($urandom_range(0, 2 * span)) - span);
      mx = (int'(s.ax0) + int'(s.ax1)) / 2;
      my = (int'(s.ay0) + int'(s.ay1)) / 2;
      s.bx0 = coord_type'(mx + $signed($urandom_range(0, 2 * span)) - span);
      s.by0 = coord_type'(my + $signed($urandom_range(0, 2 * span)) - span);
      s.bx1 = coord_type'(2 * mx - int'(s.bx0));
      s.by1 = coord_type'(2 * my - int'(s.by0));
      return s;
   endfunction

   task automatic drain();
      while (crossings_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic test_directed();
      // plain X crossing at the origin
      send_pair(mk_pair(-16, -16, 16, 16, -16, 16, 16, -16));
      // crossing at an endpoint of both (t = 0, u = 0)
      send_pair(mk_pair(0, 0, 32, 0, 0, 0, 0, 32));
      // crossing at the far ends (t = 1, u = 1)
      send_pair(mk_pair(0, 0, 32, 0, 64, 32, 32, 0));
      // parallel, collinear, zero-length segments
      send_pair(mk_pair(0, 0, 32, 0, 0, 16, 32, 16));
      send_pair(mk_pair(0, 0, 32, 0, 48, 0, 96, 0));
      send_pair(mk_pair(5, 5, 5, 5, 0, 0, 10, 10));
      // crossing outside A, then outside B
      send_pair(mk_pair(0, 0, 16, 0, 32, -16, 32, 16));
      send_pair(mk_pair(-16, 0, 16, 0, 0, 16, 0, 48));
      // extreme coordinates, diagonals of the full range
      send_pair(mk_pair(-32768, -32768, 32767, 32767,
                        -32768, 32767, 32767, -32768));
      send_pair(mk_pair(32767, -32768, -32768, 32767,
                        32767, 32767, -32768, -32768));
      send_pair(mk_pair(-32768, 0, 32767, 0, 0, -32768, 1, 32767));
      send_pair(mk_pair(32767, 32767, 32767, 32767,
                        -32768, -32768, -32768, -32768));
      // truncation toward zero with negative quotients
      send_pair(mk_pair(0, 0, -7, -3, -5, 1, 1, -4));
      send_pair(mk_pair(3, -1, -9, 5, -4, -6, 2, 7));
      idle_sender();
      drain();
   endtask

   task automatic test_random_steady();
      repeat (500) send_pair($urandom_range(0, 3) != 0 ? crossing_pair() : rand_pair());
      idle_sender();
      drain();
   endtask

   // Bursty sender against a stalling receiver; queue fills and drains.
   task automatic test_random_pressure();
      gap_enable   = 1'b1;
      stall_enable = 1'b1;
      repeat (1050) send_pair($urandom_range(0, 3) != 0 ? crossing_pair() : rand_pair());
      idle_sender();
      drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_steady();
      test_random_pressure();
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
